### hdl/rvde_pkg.sv
package rvde_pkg;

	localparam logic [6:0] OPC_LUI    = 7'h37;
	localparam logic [6:0] OPC_AUIPC  = 7'h17;
	localparam logic [6:0] OPC_JAL    = 7'h6F;
	localparam logic [6:0] OPC_JALR   = 7'h67;
	localparam logic [6:0] OPC_BRANCH = 7'h63;
	localparam logic [6:0] OPC_LOAD   = 7'h03;
	localparam logic [6:0] OPC_STORE  = 7'h23;
	localparam logic [6:0] OPC_OPIMM  = 7'h13;
	localparam logic [6:0] OPC_OP     = 7'h33;
	localparam logic [6:0] OPC_FENCE  = 7'h0F;
	localparam logic [6:0] OPC_SYSTEM = 7'h73;

	localparam logic [6:0] ALT_FUNCT7 = 7'h20;

	// ALU funct3 codes
	localparam logic [2:0] F3_ADD  = 3'd0;
	localparam logic [2:0] F3_SLL  = 3'd1;
	localparam logic [2:0] F3_SLT  = 3'd2;
	localparam logic [2:0] F3_SLTU = 3'd3;
	localparam logic [2:0] F3_XOR  = 3'd4;
	localparam logic [2:0] F3_SR   = 3'd5;
	localparam logic [2:0] F3_OR   = 3'd6;
	localparam logic [2:0] F3_AND  = 3'd7;

	// branch funct3 codes
	localparam logic [2:0] F3_BEQ  = 3'd0;
	localparam logic [2:0] F3_BNE  = 3'd1;
	localparam logic [2:0] F3_BLT  = 3'd4;
	localparam logic [2:0] F3_BGE  = 3'd5;
	localparam logic [2:0] F3_BLTU = 3'd6;
	localparam logic [2:0] F3_BGEU = 3'd7;

	localparam logic [1:0] MEM_NONE  = 2'd0;
	localparam logic [1:0] MEM_LOAD  = 2'd1;
	localparam logic [1:0] MEM_STORE = 2'd2;

	localparam logic [31:0] UIMM_MASK = 32'hFFFF_F000;
	localparam logic [31:0] LINK_OFS  = 32'd4;

	typedef struct packed {
		logic [31:0] instruction;
		logic [31:0] rs1_value;
		logic [31:0] rs2_value;
		logic [31:0] pc;
	} req_t;

	typedef struct packed {
		logic [31:0] result;
		logic        write_enable;
		logic [4:0]  dest_reg;
		logic        redirect;
		logic [31:0] target;
		logic [1:0]  mem_kind;
		logic [31:0] st_data;
		logic [2:0]  access_size;
		logic        illegal;
	} res_t;

	// decode controls handed to the execute logic
	typedef struct packed {
		logic [31:0] opa;
		logic [31:0] opb;
		logic [2:0]  alu_f3;
		logic        alu_alt;
		logic        res_en;
		logic        we;
		logic        br_op;
		logic        jump;
		logic [31:0] jump_target;
		logic [4:0]  rd;
		logic [2:0]  funct3;
		logic [1:0]  mem_kind;
		logic [31:0] st_data;
		logic [2:0]  access_size;
		logic        illegal;
	} dec_t;

endpackage

### hdl/rvde_decode.sv
module rvde_decode (
	input  rvde_pkg::req_t req,
	output rvde_pkg::dec_t dec
);
	import rvde_pkg::*;

	logic [6:0]  opcode;
	logic [2:0]  f3;
	logic        alt;
	logic [31:0] imm_i;
	logic [31:0] imm_s;
	logic [31:0] imm_b;
	logic [31:0] imm_u;
	logic [31:0] imm_j;
	logic [31:0] jalr_sum;

	assign opcode = req.instruction[6:0];
	assign f3     = req.instruction[14:12];
	assign alt    = (req.instruction[31:25] == ALT_FUNCT7);

	assign imm_i = {{20{req.instruction[31]}}, req.instruction[31:20]};
	assign imm_s = {{20{req.instruction[31]}}, req.instruction[31:25], req.instruction[11:7]};
	assign imm_b = {{19{req.instruction[31]}}, req.instruction[31], req.instruction[7],
		req.instruction[30:25], req.instruction[11:8], 1'b0};
	assign imm_u = req.instruction & UIMM_MASK;
	assign imm_j = {{11{req.instruction[31]}}, req.instruction[31], req.instruction[19:12],
		req.instruction[20], req.instruction[30:21], 1'b0};

	assign jalr_sum = req.rs1_value + imm_i;

	always_comb begin
		dec             = '0;
		dec.rd          = req.instruction[11:7];
		dec.funct3      = f3;
		dec.opa         = req.rs1_value;
		dec.opb         = req.rs2_value;
		dec.alu_f3      = F3_ADD;
		dec.mem_kind    = MEM_NONE;
		unique case (opcode)
			OPC_OP: begin
				dec.alu_f3  = f3;
				dec.alu_alt = alt;
				dec.res_en  = 1'b1;
				dec.we      = 1'b1;
			end
			OPC_OPIMM: begin
				dec.opb     = imm_i;
				dec.alu_f3  = f3;
				dec.alu_alt = (f3 == F3_SR) && alt;
				dec.res_en  = 1'b1;
				dec.we      = 1'b1;
			end
			OPC_LOAD: begin
				dec.opb         = imm_i;
				dec.res_en      = 1'b1;
				dec.we          = 1'b1;
				dec.mem_kind    = MEM_LOAD;
				dec.access_size = f3;
			end
			OPC_STORE: begin
				dec.opb         = imm_s;
				dec.res_en      = 1'b1;
				dec.mem_kind    = MEM_STORE;
				dec.access_size = f3;
				dec.st_data     = req.rs2_value;
			end
			OPC_BRANCH: begin
				dec.br_op       = 1'b1;
				dec.jump_target = req.pc + imm_b;
			end
			OPC_LUI: begin
				dec.opa    = '0;
				dec.opb    = imm_u;
				dec.res_en = 1'b1;
				dec.we     = 1'b1;
			end
			OPC_AUIPC: begin
				dec.opa    = req.pc;
				dec.opb    = imm_u;
				dec.res_en = 1'b1;
				dec.we     = 1'b1;
			end
			OPC_JAL: begin
				dec.opa         = req.pc;
				dec.opb         = LINK_OFS;
				dec.res_en      = 1'b1;
				dec.we          = 1'b1;
				dec.jump        = 1'b1;
				dec.jump_target = req.pc + imm_j;
			end
			OPC_JALR: begin
				dec.opa         = req.pc;
				dec.opb         = LINK_OFS;
				dec.res_en      = 1'b1;
				dec.we          = 1'b1;
				dec.jump        = 1'b1;
				dec.jump_target = {jalr_sum[31:1], 1'b0};
			end
			OPC_FENCE, OPC_SYSTEM: begin
			end
			default: begin
				dec.illegal = 1'b1;
			end
		endcase
		// x0 is never written
		if (dec.rd == 5'd0) begin
			dec.we = 1'b0;
		end
	end

endmodule

### hdl/rvde_alu.sv
module rvde_alu (
	input  logic [2:0]  f3,
	input  logic        alt,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] y
);
	import rvde_pkg::*;

	logic [4:0] shamt;

	assign shamt = b[4:0];

	always_comb begin
		unique case (f3)
			F3_ADD:  y = alt ? (a - b) : (a + b);
			F3_SLL:  y = a << shamt;
			F3_SLT:  y = {31'd0, ($signed(a) < $signed(b))};
			F3_SLTU: y = {31'd0, (a < b)};
			F3_XOR:  y = a ^ b;
			F3_SR:   y = alt ? 32'($signed(a) >>> shamt) : (a >> shamt);
			F3_OR:   y = a | b;
			F3_AND:  y = a & b;
			default: y = '0;
		endcase
	end

endmodule

### hdl/rvde_branch.sv
module rvde_branch (
	input  logic [2:0]  f3,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic        taken
);
	import rvde_pkg::*;

	logic eq;
	logic lt;
	logic ltu;

	assign eq  = (a == b);
	assign lt  = ($signed(a) < $signed(b));
	assign ltu = (a < b);

	always_comb begin
		unique case (f3)
			F3_BEQ:  taken = eq;
			F3_BNE:  taken = ~eq;
			F3_BLT:  taken = lt;
			F3_BGE:  taken = ~lt;
			F3_BLTU: taken = ltu;
			F3_BGEU: taken = ~ltu;
			default: taken = 1'b0;  // reserved compares never branch
		endcase
	end

endmodule

### hdl/rv32i_decode_execute.sv
// RV32I integer execute unit. Each request carries one instruction word, its two
// source register values and its pc; the unit returns the ALU result (or address,
// link value, LUI/AUIPC value), write enable, destination register, branch/jump
// redirect and target, memory access kind, store data, access size and an illegal
// opcode flag. One request is accepted every clock cycle while req_stall is low; each result
// is captured in the input register and then in the result register, the two registers that
// bracket the single pass of decode, ALU and branch compare logic. A stall on the
// result side holds the result register and stalls the request side only when both
// registers are full.
module rv32i_decode_execute (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  rvde_pkg::req_t req,
	output logic           res_valid,
	input  logic           res_stall,
	output rvde_pkg::res_t res
);
	import rvde_pkg::*;

	logic   valid_s1;
	req_t   req_s1;
	logic   valid_s2;
	res_t   res_s2;
	dec_t   dec;
	logic [31:0] alu_y;
	logic   taken;
	logic   redir;
	logic   open_s2;
	res_t   res_d;

	assign open_s2   = ~valid_s2 | ~res_stall;
	assign req_stall = valid_s1 & ~open_s2;

	rvde_decode u_decode (
		.req (req_s1),
		.dec (dec)
	);

	rvde_alu u_alu (
		.f3  (dec.alu_f3),
		.alt (dec.alu_alt),
		.a   (dec.opa),
		.b   (dec.opb),
		.y   (alu_y)
	);

	rvde_branch u_branch (
		.f3    (dec.funct3),
		.a     (req_s1.rs1_value),
		.b     (req_s1.rs2_value),
		.taken (taken)
	);

	assign redir = dec.jump | (dec.br_op & taken);

	always_comb begin
		res_d.result       = dec.res_en ? alu_y : '0;
		res_d.write_enable = dec.we;
		res_d.dest_reg     = dec.rd;
		res_d.redirect     = redir;
		res_d.target       = redir ? dec.jump_target : '0;
		res_d.mem_kind     = dec.mem_kind;
		res_d.st_data      = dec.st_data;
		res_d.access_size  = dec.access_size;
		res_d.illegal      = dec.illegal;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!req_stall) begin
				valid_s1 <= req_valid;
			end
			if (open_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
		if (valid_s1 && open_s2) begin
			res_s2 <= res_d;
		end
	end

	assign res_valid = valid_s2;
	assign res       = res_s2;

endmodule

### sim/tb_rv32i_decode_execute.sv
module tb_rv32i_decode_execute;
	import rvde_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int RANDOM_REQS = 900;
	// load/store widths and a reserved branch compare, not in the package
	localparam logic [2:0] SZ_WORD = 3'd2;
	localparam logic [2:0] SZ_RSV = 3'd3;
	localparam logic [2:0] BR_RSV = 3'd2;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req_bus = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res_bus;

	req_t pending_reqs[$];
	res_t expected_res[$];
	int drain_marks[$];
	logic drained = 1'b1;
	int sent_cnt = 0;
	int gap_left = 0;
	int burst_left = 1;
	int stall_mode = 0;
	int seg_left = 0;
	int quiet_cycles = 0;
	int fail_cnt = 0;

	rv32i_decode_execute dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req_bus),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res_bus)
	);

	function automatic logic [31:0] alu_op(logic [2:0] f3, logic alt, logic [31:0] a,
			logic [31:0] b);
		case (f3)
			F3_ADD: return alt ? a - b : a + b;
			F3_SLL: return a << b[4:0];
			F3_SLT: return {31'b0, $signed(a) < $signed(b)};
			F3_SLTU: return {31'b0, a < b};
			F3_XOR: return a ^ b;
			F3_SR: return alt ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
			F3_OR: return a | b;
			default: return a & b;
		endcase
	endfunction

	function automatic res_t predict_exec(req_t r);
		res_t o;
		logic [31:0] w, a, b, imm_i, imm_s, imm_b, imm_j;
		logic [2:0] f3;
		logic alt, taken;
		w = r.instruction;
		a = r.rs1_value;
		b = r.rs2_value;
		f3 = w[14:12];
		alt = w[31:25] == ALT_FUNCT7;
		imm_i = {{20{w[31]}}, w[31:20]};
		imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
		imm_b = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
		imm_j = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
		o = '0;
		o.dest_reg = w[11:7];
		case (w[6:0])
			OPC_OP: begin
				o.result = alu_op(f3, alt, a, b);
				o.write_enable = 1'b1;
			end
			OPC_OPIMM: begin
				o.result = alu_op(f3, f3 == F3_SR && alt, a, imm_i);
				o.write_enable = 1'b1;
			end
			OPC_LOAD: begin
				o.result = a + imm_i;
				o.write_enable = 1'b1;
				o.mem_kind = MEM_LOAD;
				o.access_size = f3;
			end
			OPC_STORE: begin
				o.result = a + imm_s;
				o.mem_kind = MEM_STORE;
				o.access_size = f3;
				o.st_data = b;
			end
			OPC_BRANCH: begin
				case (f3)
					F3_BEQ: taken = a == b;
					F3_BNE: taken = a != b;
					F3_BLT: taken = $signed(a) < $signed(b);
					F3_BGE: taken = $signed(a) >= $signed(b);
					F3_BLTU: taken = a < b;
					F3_BGEU: taken = a >= b;
					default: taken = 1'b0;
				endcase
				if (taken) begin
					o.redirect = 1'b1;
					o.target = r.pc + imm_b;
				end
			end
			OPC_LUI: begin
				o.result = w & UIMM_MASK;
				o.write_enable = 1'b1;
			end
			OPC_AUIPC: begin
				o.result = r.pc + (w & UIMM_MASK);
				o.write_enable = 1'b1;
			end
			OPC_JAL: begin
				o.result = r.pc + LINK_OFS;
				o.write_enable = 1'b1;
				o.redirect = 1'b1;
				o.target = r.pc + imm_j;
			end
			OPC_JALR: begin
				o.result = r.pc + LINK_OFS;
				o.write_enable = 1'b1;
				o.redirect = 1'b1;
				o.target = (a + imm_i) & ~32'd1;
			end
			OPC_FENCE, OPC_SYSTEM: ;
			default: o.illegal = 1'b1;
		endcase
		if (o.dest_reg == 5'd0)
			o.write_enable = 1'b0;
		return o;
	endfunction

	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 7))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			4: return $urandom_range(0, 64);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [6:0] pick_funct7();
		case ($urandom_range(0, 3))
			0, 1: return 7'h00;
			2: return ALT_FUNCT7;
			default: return 7'($urandom);
		endcase
	endfunction

	task automatic add_req(logic [31:0] w, logic [31:0] a, logic [31:0] b, logic [31:0] pc);
		pending_reqs.push_back({w, a, b, pc});
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_cnt++;
		end
	endtask

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		logic [31:0] w, a, b;
		int pick;
		// register-register ops, both funct7 selections and an odd funct7
		add_req({7'h00, 5'd2, 5'd1, F3_ADD, 5'd3, OPC_OP}, 32'hFFFF_FFFF, 32'h1, 32'h0);
		add_req({ALT_FUNCT7, 5'd2, 5'd1, F3_ADD, 5'd3, OPC_OP}, 32'h0, 32'h1, 32'h0);
		add_req({7'h00, 5'd2, 5'd1, F3_SLL, 5'd3, OPC_OP}, 32'h1, 32'hFFFF_FFFF, 32'h0);
		add_req({7'h00, 5'd2, 5'd1, F3_SLT, 5'd3, OPC_OP}, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
		add_req({7'h00, 5'd2, 5'd1, F3_SLTU, 5'd3, OPC_OP}, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h0);
		add_req({7'h00, 5'd2, 5'd1, F3_XOR, 5'd3, OPC_OP}, 32'hFFFF_FFFF, 32'h5555_5555, 32'h0);
		add_req({7'h00, 5'd2, 5'd1, F3_SR, 5'd3, OPC_OP}, 32'h8000_0000, 32'h4, 32'h0);
		add_req({ALT_FUNCT7, 5'd2, 5'd1, F3_SR, 5'd3, OPC_OP}, 32'h8000_0000, 32'h4, 32'h0);
		add_req({7'h00, 5'd2, 5'd1, F3_OR, 5'd3, OPC_OP}, 32'h0, 32'hFFFF_FFFF, 32'h0);
		add_req({7'h00, 5'd2, 5'd1, F3_AND, 5'd3, OPC_OP}, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
		add_req({7'h21, 5'd2, 5'd1, F3_SR, 5'd3, OPC_OP}, 32'hFFFF_FFFF, 32'h1F, 32'h0);
		// arithmetic shift immediate by 31
		add_req({ALT_FUNCT7, 5'd31, 5'd1, F3_SR, 5'd3, OPC_OPIMM}, 32'h8000_0000, 32'h0, 32'h0);
		// reserved load width, most negative offset
		add_req({12'h800, 5'd1, SZ_RSV, 5'd3, OPC_LOAD}, 32'h0, 32'h0, 32'h0);
		add_req({7'h3F, 5'd2, 5'd1, SZ_WORD, 5'h1F, OPC_STORE}, 32'hFFFF_FFFF, 32'hDEAD_BEEF,
			32'hFFFF_FFFF);
		add_req({1'b1, 6'h3F, 5'd2, 5'd1, F3_BEQ, 4'hF, 1'b1, OPC_BRANCH}, 32'h5, 32'h5, 32'h0);
		add_req({1'b0, 6'h3F, 5'd2, 5'd1, F3_BLT, 4'hF, 1'b1, OPC_BRANCH}, 32'hFFFF_FFFF, 32'h0,
			32'hFFFF_FFFF);
		add_req({1'b0, 6'h01, 5'd2, 5'd1, F3_BGEU, 4'h2, 1'b0, OPC_BRANCH}, 32'h0,
			32'hFFFF_FFFF, 32'h100);
		add_req({1'b0, 6'h01, 5'd2, 5'd1, BR_RSV, 4'h2, 1'b0, OPC_BRANCH}, 32'h7, 32'h7, 32'h100);
		// LUI to x0 must not write
		add_req({20'hFFFFF, 5'd0, OPC_LUI}, 32'h0, 32'h0, 32'h0);
		add_req({20'h80000, 5'd3, OPC_AUIPC}, 32'h0, 32'h0, 32'h8000_0000);
		add_req({1'b1, 10'h000, 1'b0, 8'h00, 5'd1, OPC_JAL}, 32'h0, 32'h0, 32'h0);
		// odd target, nonzero funct3
		add_req({12'h001, 5'd1, 3'h5, 5'd31, OPC_JALR}, 32'h0, 32'h0, 32'hFFFF_FFFC);
		add_req({25'h1FF_FFFF, OPC_FENCE}, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
		add_req({25'h1FF_FFFF, OPC_SYSTEM}, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
		add_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_req(32'h0, 32'h0, 32'h0, 32'h0);

		drain_marks.push_back(26);
		drain_marks.push_back($urandom_range(100, 300));
		drain_marks.push_back($urandom_range(400, 600));
		drain_marks.push_back($urandom_range(700, 900));

		for (int n = 0; n < RANDOM_REQS; n++) begin
			w = $urandom;
			pick = $urandom_range(0, 99);
			if (pick < 16) begin
				w[6:0] = OPC_OP;
				w[31:25] = pick_funct7();
			end else if (pick < 30) begin
				w[6:0] = OPC_OPIMM;
				if (w[13:12] == 2'b01)
					w[31:25] = pick_funct7();
			end else if (pick < 40)
				w[6:0] = OPC_LOAD;
			else if (pick < 50)
				w[6:0] = OPC_STORE;
			else if (pick < 66)
				w[6:0] = OPC_BRANCH;
			else if (pick < 71)
				w[6:0] = OPC_LUI;
			else if (pick < 76)
				w[6:0] = OPC_AUIPC;
			else if (pick < 82)
				w[6:0] = OPC_JAL;
			else if (pick < 88)
				w[6:0] = OPC_JALR;
			else if (pick < 90)
				w[6:0] = OPC_FENCE;
			else if (pick < 92)
				w[6:0] = OPC_SYSTEM;
			if ($urandom_range(0, 9) == 0)
				w[11:7] = 5'd0;
			a = pick_operand();
			b = ($urandom_range(0, 3) == 0) ? a : pick_operand();
			add_req(w, a, b, pick_operand());
		end

		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		do
			@(negedge clk);
		while (pending_reqs.size() != 0 || req_valid || !drained);
		repeat (8) @(negedge clk);
		if (fail_cnt == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// request driver: bursts with gaps, holds off at drain marks until all results are back
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req_bus <= '0;
		end else if (!req_valid || !req_stall) begin
			if (gap_left > 0) begin
				gap_left--;
				req_valid <= 1'b0;
			end else if (pending_reqs.size() == 0 || (drain_marks.size() != 0 &&
					sent_cnt == drain_marks[0] && (req_valid || !drained))) begin
				req_valid <= 1'b0;
			end else begin
				if (drain_marks.size() != 0 && sent_cnt == drain_marks[0])
					void'(drain_marks.pop_front());
				req_bus <= pending_reqs.pop_front();
				req_valid <= 1'b1;
				sent_cnt++;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 48);
					gap_left = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 10) :
						$urandom_range(0, 2);
				end
			end
		end
	end

	// result stall pattern: segments of no stall, light, heavy and periodic stalling
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			if (seg_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				seg_left = $urandom_range(20, 200);
			end else
				seg_left--;
			case (stall_mode)
				0: res_stall <= 1'b0;
				1: res_stall <= $urandom_range(0, 3) == 0;
				2: res_stall <= $urandom_range(0, 3) != 0;
				default: res_stall <= (seg_left % 12) < 5;
			endcase
		end
	end

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			drained <= 1'b1;
		end else begin
			if (res_valid && !res_stall) begin
				if (expected_res.size() == 0) begin
					$error("result with no request outstanding");
					fail_cnt++;
				end else begin
					want = expected_res.pop_front();
					check_field("result", want.result, res_bus.result);
					check_field("write_enable", want.write_enable, res_bus.write_enable);
					check_field("dest_reg", want.dest_reg, res_bus.dest_reg);
					check_field("redirect", want.redirect, res_bus.redirect);
					check_field("target", want.target, res_bus.target);
					check_field("mem_kind", want.mem_kind, res_bus.mem_kind);
					check_field("st_data", want.st_data, res_bus.st_data);
					check_field("access_size", want.access_size, res_bus.access_size);
					check_field("illegal", want.illegal, res_bus.illegal);
				end
			end
			if (req_valid && !req_stall)
				expected_res.push_back(predict_exec(req_bus));
			drained <= expected_res.size() == 0;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (res_valid && !res_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

endmodule
